/* hdl/cmaec_pkg.sv */
// Shared constants, types and codes of the centered moving average block.
package cmaec_pkg;

  localparam int WINDOW_SPAN = 10;
  localparam int HALF        = WINDOW_SPAN / 2;
  localparam int TAPS        = 2 * HALF + 1;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + $clog2(TAPS);
  localparam int SEEN_W   = $clog2(HALF + 2);
  localparam int FLUSH_W  = $clog2(HALF + 1);

  // Division by TAPS is a multiplication by a rounded-up reciprocal. The
  // error of the reciprocal times the largest sum stays below one unit of
  // the shifted product, so the quotient is exact for every sum.
  localparam int RECIP_SHIFT = SUM_W + $clog2(TAPS);
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + TAPS - 1) / TAPS;
  localparam int PROD_W = SUM_W + RECIP_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_PUSH,
    OP_PUSH_END
  } op_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    op_t                 op;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             final_flag;
  } emit_t;

endpackage

/* hdl/cmaec_queue.sv */
// Front part: accepts samples, classifies them and queues them for the window engine.
module cmaec_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cmaec_pkg::SAMPLE_W-1:0] sample,
  input  logic                          frame_end,
  output logic                          q_valid,
  input  logic                          q_ready,
  output cmaec_pkg::entry_t             q_entry
);

  cmaec_pkg::entry_t                q_mem [cmaec_pkg::QUEUE_DEPTH];
  logic [cmaec_pkg::QPTR_W-1:0]     wr_ptr;
  logic [cmaec_pkg::QPTR_W-1:0]     rd_ptr;
  logic [cmaec_pkg::QCNT_W-1:0]     count;
  logic                             wr_en;
  logic                             rd_en;
  cmaec_pkg::entry_t                new_entry;

  localparam logic [cmaec_pkg::QPTR_W-1:0] LAST_PTR =
    cmaec_pkg::QPTR_W'(cmaec_pkg::QUEUE_DEPTH - 1);
  localparam logic [cmaec_pkg::QCNT_W-1:0] FULL_CNT =
    cmaec_pkg::QCNT_W'(cmaec_pkg::QUEUE_DEPTH);

  assign in_ready = (count != FULL_CNT);
  assign q_valid  = (count != '0);
  assign wr_en    = in_valid && in_ready;
  assign rd_en    = q_valid && q_ready;
  assign q_entry  = q_mem[rd_ptr];

  always_comb begin
    new_entry.sample = sample;
    new_entry.op     = frame_end ? cmaec_pkg::OP_PUSH_END : cmaec_pkg::OP_PUSH;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue fill count beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    (count == FULL_CNT) |=> (count == FULL_CNT) || ($past(rd_en)))
    else $error("queue grew while full");

endmodule

/* hdl/cmaec_window.sv */
// Back part: window shift line, running sum and frame-end flush sequencer.
module cmaec_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  cmaec_pkg::entry_t q_entry,
  output logic              emit_valid,
  input  logic              emit_ready,
  output cmaec_pkg::emit_t  emit_data
);

  localparam logic [cmaec_pkg::SEEN_W-1:0] SEEN_FULL =
    cmaec_pkg::SEEN_W'(cmaec_pkg::HALF + 1);

  logic [cmaec_pkg::SAMPLE_W-1:0] win [cmaec_pkg::TAPS];
  logic [cmaec_pkg::SUM_W-1:0]    sum;
  logic [cmaec_pkg::SUM_W-1:0]    sum_next;
  logic [cmaec_pkg::SEEN_W-1:0]   seen;
  logic [cmaec_pkg::SEEN_W-1:0]   seen_inc;
  logic                           flushing;
  logic [cmaec_pkg::FLUSH_W-1:0]  flush_cnt;
  logic [cmaec_pkg::SAMPLE_W-1:0] flush_x;
  logic [cmaec_pkg::SAMPLE_W-1:0] cur_x;
  logic                           s1_ready;
  logic                           step;
  logic                           last_flush;
  logic                           emit;
  logic                           s1_valid;
  cmaec_pkg::emit_t               s1_data;

  assign s1_ready   = !s1_valid || emit_ready;
  assign step       = (flushing || q_valid) && s1_ready;
  assign q_ready    = s1_ready && !flushing;
  assign cur_x      = flushing ? flush_x : q_entry.sample;
  assign last_flush = flushing && (flush_cnt == cmaec_pkg::FLUSH_W'(1));
  assign seen_inc   = (seen < SEEN_FULL) ? seen + 1'b1 : seen;
  assign emit       = (seen_inc == SEEN_FULL);

  // The first sample of a frame stands in for every position before it.
  always_comb begin
    if (seen == '0) begin
      sum_next = cmaec_pkg::SUM_W'(cur_x) * cmaec_pkg::SUM_W'(cmaec_pkg::TAPS);
    end else begin
      sum_next = sum - cmaec_pkg::SUM_W'(win[0]) + cmaec_pkg::SUM_W'(cur_x);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sum <= sum_next;
      for (int i = 0; i < cmaec_pkg::TAPS - 1; i++) begin
        if (seen == '0) begin
          win[i] <= cur_x;
        end else begin
          win[i] <= win[i + 1];
        end
      end
      win[cmaec_pkg::TAPS - 1] <= cur_x;
      if (!flushing) begin
        flush_x <= cur_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      flushing  <= 1'b0;
      flush_cnt <= '0;
    end else if (step) begin
      seen <= last_flush ? '0 : seen_inc;
      if (flushing) begin
        flush_cnt <= flush_cnt - 1'b1;
        if (last_flush) begin
          flushing <= 1'b0;
        end
      end else if (q_entry.op == cmaec_pkg::OP_PUSH_END) begin
        // The last sample is pushed HALF more times to clamp the far edge.
        flushing  <= 1'b1;
        flush_cnt <= cmaec_pkg::FLUSH_W'(cmaec_pkg::HALF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_data.sum        <= sum_next;
      s1_data.final_flag <= last_flush;
    end
  end

  assign emit_valid = s1_valid;
  assign emit_data  = s1_data;

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= SEEN_FULL)
    else $error("push count above saturation");

  a_flush_started: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (seen != '0))
    else $error("flush running on an empty window");

  a_flush_ends_clean: assert property (@(posedge clk) disable iff (rst)
    (step && last_flush) |=> (seen == '0) && !flushing && s1_valid && s1_data.final_flag)
    else $error("frame end did not emit a marked result and restart");

  a_no_pop_in_flush: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !q_ready)
    else $error("queue popped during flush");

endmodule

/* hdl/cmaec_div.sv */
// Division of the window sum by the tap count and the output register.
module cmaec_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           emit_valid,
  output logic                           emit_ready,
  input  cmaec_pkg::emit_t               emit_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cmaec_pkg::SAMPLE_W-1:0] average,
  output logic                           final_output
);

  localparam logic [cmaec_pkg::RECIP_SHIFT-1:0] RECIP =
    cmaec_pkg::RECIP_SHIFT'(cmaec_pkg::RECIP_VAL);

  logic [cmaec_pkg::PROD_W-1:0] prod;
  logic                         fin;

  assign emit_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready) begin
      prod <= cmaec_pkg::PROD_W'(emit_data.sum) * cmaec_pkg::PROD_W'(RECIP);
      fin  <= emit_data.final_flag;
    end
  end

  assign average      = prod[cmaec_pkg::RECIP_SHIFT +: cmaec_pkg::SAMPLE_W];
  assign final_output = fin;

endmodule

/* hdl/centered_moving_average_edge_clamp_top.sv */
// Top level of the 11-tap centered moving average with edge clamp.
// Samples are taken one per cycle while the four-entry input queue has room. Each
// ordinary sample makes one push into the window engine, and a sample marked frame_end
// is followed by HALF replays of itself to flush the frame, the running sum taking one
// clamped push per cycle while the output does not stall. The input queue keeps accepting
// during that flush until full. A result is registered twice after the window push that
// produces it: the push loads the sum register, then the reciprocal multiply loads the
// output register. Results lag the input stream by five samples; the last result of each
// frame carries final_output.
module centered_moving_average_edge_clamp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] average,
  output logic        final_output
);

  logic              q_valid;
  logic              q_ready;
  cmaec_pkg::entry_t q_entry;
  logic              emit_valid;
  logic              emit_ready;
  cmaec_pkg::emit_t  emit_data;

  cmaec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .frame_end (frame_end),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry)
  );

  cmaec_window u_window (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data)
  );

  cmaec_div u_div (
    .clk          (clk),
    .rst          (rst),
    .emit_valid   (emit_valid),
    .emit_ready   (emit_ready),
    .emit_data    (emit_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average      (average),
    .final_output (final_output)
  );

endmodule

/* tb/centered_moving_average_edge_clamp_top_tb.sv */
// Self-checking testbench for the 11-tap centered moving average with edge clamp.
`timescale 1ns / 1ps

module centered_moving_average_edge_clamp_top_tb;

  localparam int IDLE_LIMIT  = 4000;
  localparam int QUIET_SPAN  = 12;
  localparam int END_SETTLE  = 24;
  localparam int RANDOM_ITEMS = 345;

  typedef struct {
    logic [cmaec_pkg::SAMPLE_W-1:0] value;
    logic                           end_of_frame;
    bit                             hold_until_drained;
  } sample_item_t;

  typedef struct {
    logic [cmaec_pkg::SAMPLE_W-1:0] average;
    logic                           final_flag;
  } avg_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [cmaec_pkg::SAMPLE_W-1:0] sample = '0;
  logic                           frame_end = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [cmaec_pkg::SAMPLE_W-1:0] average;
  logic                           final_output;

  centered_moving_average_edge_clamp_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average      (average),
    .final_output (final_output)
  );

  always #4 clk = ~clk;

  sample_item_t sample_q[$];
  avg_result_t  expected_avg[$];
  int           pending_n = 0;
  int           errors = 0;
  int           samples_in = 0;
  int           frames_in = 0;
  int           averages_out = 0;
  int           drain_pauses = 0;

  // Predictor state: clamped window, its running sum and the fill count.
  logic [cmaec_pkg::SAMPLE_W-1:0] win [cmaec_pkg::TAPS];
  int unsigned                    win_sum = 0;
  int unsigned                    fill_cnt = 0;

  task automatic clear_window();
    for (int i = 0; i < cmaec_pkg::TAPS; i++) win[i] = '0;
    win_sum  = 0;
    fill_cnt = 0;
  endtask

  task automatic window_push(input logic [cmaec_pkg::SAMPLE_W-1:0] x);
    avg_result_t res;
    int unsigned q;
    if (fill_cnt == 0) begin
      for (int i = 0; i < cmaec_pkg::TAPS; i++) win[i] = x;
      win_sum = int'(x) * cmaec_pkg::TAPS;
    end else begin
      win_sum -= int'(win[0]);
      for (int i = 0; i < cmaec_pkg::TAPS - 1; i++) win[i] = win[i+1];
      win[cmaec_pkg::TAPS-1] = x;
      win_sum += int'(x);
    end
    if (fill_cnt < cmaec_pkg::HALF + 1) fill_cnt++;
    if (fill_cnt >= cmaec_pkg::HALF + 1) begin
      q = win_sum / cmaec_pkg::TAPS;
      res.average    = q[cmaec_pkg::SAMPLE_W-1:0];
      res.final_flag = 1'b0;
      expected_avg.push_back(res);
    end
  endtask

  // The last sample of a frame is replayed HALF more times to flush the window.
  task automatic predict_averages(input logic [cmaec_pkg::SAMPLE_W-1:0] x, input logic last);
    int          n_before;
    avg_result_t res;
    n_before = expected_avg.size();
    window_push(x);
    if (last) begin
      for (int k = 0; k < cmaec_pkg::HALF; k++) window_push(x);
      if (expected_avg.size() > n_before) begin
        res = expected_avg.pop_back();
        res.final_flag = 1'b1;
        expected_avg.push_back(res);
      end
      clear_window();
    end
  endtask

  function automatic logic [cmaec_pkg::SAMPLE_W-1:0] pick_value(input int style,
                                                               input int idx);
    logic [cmaec_pkg::SAMPLE_W-1:0] v;
    case (style)
      0: v = cmaec_pkg::SAMPLE_W'($urandom_range(0, 65535));
      1: v = cmaec_pkg::SAMPLE_W'(65535 - $urandom_range(0, 15));
      2: v = cmaec_pkg::SAMPLE_W'($urandom_range(0, 15));
      3: v = 16'h8001;
      default: v = idx[0] ? 16'hFFFF : 16'h0000;
    endcase
    return v;
  endfunction

  task automatic add_frame(input int len, input int style, input bit hold);
    sample_item_t it;
    for (int i = 0; i < len; i++) begin
      it.value              = pick_value(style, i);
      it.end_of_frame       = (i == len - 1);
      it.hold_until_drained = hold && (i == 0);
      sample_q.push_back(it);
    end
  endtask

  task automatic add_fixed(input logic [cmaec_pkg::SAMPLE_W-1:0] v, input logic last);
    sample_item_t it;
    it.value              = v;
    it.end_of_frame       = last;
    it.hold_until_drained = 1'b0;
    sample_q.push_back(it);
  endtask

  // Sender: bursts of random length separated by random gaps.
  sample_item_t nxt;
  int           burst_left = 0;
  int           gap_left = 0;
  int           quiet = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        nxt = sample_q[0];
        if (nxt.hold_until_drained && quiet < QUIET_SPAN) begin
          // Hold back until every predicted average has been taken.
          if (pending_n == 0 && !in_valid) quiet++;
          else quiet = 0;
          in_valid <= 1'b0;
        end else begin
          if (nxt.hold_until_drained) drain_pauses++;
          quiet = 0;
          void'(sample_q.pop_front());
          in_valid  <= 1'b1;
          sample    <= nxt.value;
          frame_end <= nxt.end_of_frame;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: keeps a randomly chosen stall pattern for a random stretch, then picks another.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 120);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_phase % 7) < 4;
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  avg_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      pending_n <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_averages(sample, frame_end);
        samples_in++;
        if (frame_end) frames_in++;
      end
      if (out_valid && out_ready) begin
        averages_out++;
        if (expected_avg.size() == 0) begin
          $error("unexpected result: average=%0d final_output=%0b", average, final_output);
          errors++;
        end else begin
          want = expected_avg.pop_front();
          if (average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, average);
            errors++;
          end
          if (final_output !== want.final_flag) begin
            $error("final_output: expected %0b, actual %0b", want.final_flag, final_output);
            errors++;
          end
        end
      end
      pending_n <= expected_avg.size();
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int start_n;
    int len;
    int r;
    clear_window();

    // Directed: one-sample frames at both extremes, a two-sample frame, a frame
    // just long enough to fill half the window, a full-scale frame and bit patterns.
    add_fixed(16'h0000, 1'b1);
    add_fixed(16'hFFFF, 1'b1);
    add_fixed(16'hFFFF, 1'b0);
    add_fixed(16'h0000, 1'b1);
    for (int i = 0; i < 6; i++) add_fixed(cmaec_pkg::SAMPLE_W'(i * 13107), i == 5);
    for (int i = 0; i < 11; i++) add_fixed(16'hFFFF, i == 10);
    add_fixed(16'h5555, 1'b0);
    add_fixed(16'hAAAA, 1'b1);

    start_n = sample_q.size();
    while (sample_q.size() - start_n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 3) len = $urandom_range(1, 6);
      else if (r < 9) len = $urandom_range(7, 24);
      else len = $urandom_range(25, 60);
      add_frame(len, $urandom_range(0, 4),
                (sample_q.size() == start_n) || ($urandom_range(0, 7) == 0));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_n != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    $display("Covered %0d frames (%0d samples, %0d averages) under bursty input,", frames_in,
             samples_in, averages_out);
    $display("varied output stalls and %0d full drain pauses; %0d mismatches.", drain_pauses,
             errors);
    if (errors == 0 && expected_avg.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
